>>> hw/rtl/xcr_pkg.sv
package xcr_pkg;

	// Frame geometry
	localparam int PAYLOAD_BYTES = 128;
	localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
	localparam int POS_W         = 8;
	localparam int PKT_W         = 11;
	localparam int OFS_W         = 18;
	localparam int AREA_BYTES    = 1 << OFS_W;

	localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(3 + PAYLOAD_BYTES);
	localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(4 + PAYLOAD_BYTES);

	// Line characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Register defaults and indexes
	localparam logic [7:0] RETRY_LIMIT_RST   = 8'd10;
	localparam logic [7:0] ATTEMPT_LIMIT_RST = 8'd60;

	typedef enum logic {
		REG_RETRY_LIMIT   = 1'b0,
		REG_ATTEMPT_LIMIT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_TIMEOUT = 2'd1,
		CMD_START   = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_START  = 3'd1,
		PH_XFER   = 3'd2,
		PH_DONE   = 3'd3,
		PH_CANCEL = 3'd4,
		PH_FAIL   = 3'd5
	} phase_t;

	// One result item, send_count in the lowest bits
	typedef struct packed {
		logic [2:0]       session_status;
		logic             packet_discard;
		logic             packet_commit;
		logic [7:0]       data_byte;
		logic [OFS_W-1:0] data_offset;
		logic             data_valid;
		logic [7:0]       send_byte;
		logic [1:0]       send_count;
	} result_t;

	localparam int RES_W   = $bits(result_t);
	localparam int MDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int SDATA_W = 16;

	// CRC-16/XMODEM update over one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/xcr_engine.sv
module xcr_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [1:0]             command,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             retry_limit,
	input  logic [7:0]             start_attempt_limit,
	output xcr_pkg::result_t       result
);

	xcr_pkg::phase_t                 phase_q, phase_d;
	logic [xcr_pkg::POS_W-1:0]       fpos_q, fpos_d;
	logic [7:0]                      seq_q, seq_d;
	logic [7:0]                      seqn_q, seqn_d;
	logic [15:0]                     crc_q, crc_d;
	logic [7:0]                      crc_hi_q, crc_hi_d;
	logic [7:0]                      exp_q, exp_d;
	logic [7:0]                      retry_q, retry_d;
	logic [7:0]                      attempt_q, attempt_d;
	logic [xcr_pkg::PKT_W-1:0]       pw_q, pw_d;

	logic                            active;
	logic                            fail;
	logic                            good;
	logic [8:0]                      retry_inc;
	logic [xcr_pkg::POS_W-1:0]       idx;
	xcr_pkg::result_t                res;

	assign active    = (phase_q == xcr_pkg::PH_START) || (phase_q == xcr_pkg::PH_XFER);
	assign retry_inc = {1'b0, retry_q} + 9'd1;
	assign idx       = fpos_q - xcr_pkg::POS_FIRST;
	assign good      = (seq_q == exp_q) && (seqn_q == ~exp_q) && ({crc_hi_q, rx_byte} == crc_q);

	// Work out the result and the next state for the item in hand
	always_comb begin
		phase_d   = phase_q;
		fpos_d    = fpos_q;
		seq_d     = seq_q;
		seqn_d    = seqn_q;
		crc_d     = crc_q;
		crc_hi_d  = crc_hi_q;
		exp_d     = exp_q;
		retry_d   = retry_q;
		attempt_d = attempt_q;
		pw_d      = pw_q;
		res       = '0;
		fail      = 1'b0;

		unique case (command)
			xcr_pkg::CMD_START: begin
				res.packet_discard = active && (fpos_q != '0);
				phase_d   = xcr_pkg::PH_START;
				fpos_d    = '0;
				crc_d     = '0;
				exp_d     = 8'd1;
				retry_d   = '0;
				attempt_d = 8'd1;
				pw_d      = '0;
				res.send_count = 2'd1;
				res.send_byte  = xcr_pkg::CH_C;
			end
			xcr_pkg::CMD_TIMEOUT: begin
				fail = active;
			end
			xcr_pkg::CMD_BYTE: begin
				if (active) begin
					if (fpos_q == '0) begin
						// header byte
						if (rx_byte == xcr_pkg::CH_SOH) begin
							fpos_d = xcr_pkg::POS_W'(1);
							crc_d  = '0;
						end else if (rx_byte == xcr_pkg::CH_EOT && phase_q == xcr_pkg::PH_XFER) begin
							phase_d        = xcr_pkg::PH_DONE;
							res.send_count = 2'd1;
							res.send_byte  = xcr_pkg::CH_ACK;
						end else if (rx_byte == xcr_pkg::CH_CAN && phase_q == xcr_pkg::PH_XFER) begin
							phase_d = xcr_pkg::PH_CANCEL;
						end else begin
							fail = 1'b1;
						end
					end else if (fpos_q == xcr_pkg::POS_W'(1)) begin
						seq_d  = rx_byte;
						fpos_d = xcr_pkg::POS_W'(2);
					end else if (fpos_q == xcr_pkg::POS_W'(2)) begin
						seqn_d = rx_byte;
						fpos_d = xcr_pkg::POS_FIRST;
					end else if (fpos_q < xcr_pkg::POS_CRC_HI) begin
						// payload byte: stream it out, offset wraps with the area
						res.data_valid  = 1'b1;
						res.data_offset = xcr_pkg::OFS_W'({pw_q, idx[xcr_pkg::IDX_W-1:0]});
						res.data_byte   = rx_byte;
						crc_d  = xcr_pkg::crc_byte(crc_q, rx_byte);
						fpos_d = fpos_q + xcr_pkg::POS_W'(1);
					end else if (fpos_q == xcr_pkg::POS_CRC_HI) begin
						crc_hi_d = rx_byte;
						fpos_d   = fpos_q + xcr_pkg::POS_W'(1);
					end else if (fpos_q == xcr_pkg::POS_CRC_LO && good) begin
						fpos_d            = '0;
						res.packet_commit = 1'b1;
						exp_d             = exp_q + 8'd1;
						pw_d              = pw_q + xcr_pkg::PKT_W'(1);
						retry_d           = '0;
						phase_d           = xcr_pkg::PH_XFER;
						res.send_count    = 2'd1;
						res.send_byte     = xcr_pkg::CH_ACK;
					end else begin
						fail = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// Failure: 'C' again or fail while starting, NAK or cancel in transfer
		if (fail) begin
			res.packet_discard = (fpos_q != '0);
			fpos_d = '0;
			if (phase_q == xcr_pkg::PH_START) begin
				if (attempt_q < start_attempt_limit) begin
					attempt_d      = attempt_q + 8'd1;
					res.send_count = 2'd1;
					res.send_byte  = xcr_pkg::CH_C;
				end else begin
					phase_d = xcr_pkg::PH_FAIL;
				end
			end else begin
				retry_d = retry_inc[7:0];
				if (retry_inc > {1'b0, retry_limit}) begin
					phase_d        = xcr_pkg::PH_FAIL;
					res.send_count = 2'd2;
					res.send_byte  = xcr_pkg::CH_CAN;
				end else begin
					res.send_count = 2'd1;
					res.send_byte  = xcr_pkg::CH_NAK;
				end
			end
		end

		res.session_status = phase_d;
	end

	assign result = res;

	// Session state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= xcr_pkg::PH_IDLE;
			fpos_q    <= '0;
			seq_q     <= '0;
			seqn_q    <= '0;
			crc_q     <= '0;
			crc_hi_q  <= '0;
			exp_q     <= 8'd1;
			retry_q   <= '0;
			attempt_q <= '0;
			pw_q      <= '0;
		end else if (en) begin
			phase_q   <= phase_d;
			fpos_q    <= fpos_d;
			seq_q     <= seq_d;
			seqn_q    <= seqn_d;
			crc_q     <= crc_d;
			crc_hi_q  <= crc_hi_d;
			exp_q     <= exp_d;
			retry_q   <= retry_d;
			attempt_q <= attempt_d;
			pw_q      <= pw_d;
		end
	end

	a_fpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		fpos_q <= xcr_pkg::POS_CRC_LO)
		else $error("frame position past the CRC low byte");

	a_commit_seq: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.packet_commit |=> exp_q == $past(exp_q) + 8'd1 && fpos_q == '0)
		else $error("commit did not advance the sequence number");

	a_cancel_fail: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.send_count == 2'd2 |=> phase_q == xcr_pkg::PH_FAIL)
		else $error("double cancel without failed session");

	a_data_step: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.data_valid |=> fpos_q == $past(fpos_q) + xcr_pkg::POS_W'(1))
		else $error("payload byte did not advance the frame position");

endmodule

>>> hw/rtl/xmodem_crc_receiver_top.sv
// Channel   Dir  Width  Contents
// s_*       in   16     command, rx_byte
// m_*       out  48     send_count .. session_status, one item per input item
// cfg_*     in   8      retry_limit (index 0), start_attempt_limit (index 1)
//
// One input item yields one result item: an input register holds it,
// then the protocol engine feeds the output register. Sustained rate is
// one item per cycle while m_tready is high; the frame/CRC update is single pass.
// arst_n clears the session to idle and loads the register defaults.
// A stalled output holds its item; the input register fills behind it and
// then s_tready drops until m_tready returns.
module xmodem_crc_receiver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [xcr_pkg::SDATA_W-1:0]  s_tdata,  // [1:0] command, [9:2] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [1:0] send_count, [9:2] send_byte, [10] data_valid, [28:11] data_offset,
	// [36:29] data_byte, [37] packet_commit, [38] packet_discard,
	// [41:39] session_status
	output logic [xcr_pkg::MDATA_W-1:0]  m_tdata,
	input  logic                         cfg_wen,
	input  logic                         cfg_index,
	input  logic [7:0]                   cfg_wdata
);

	logic             valid_s1;
	logic [1:0]       command_s1;
	logic [7:0]       rx_byte_s1;
	logic             valid_s2;
	xcr_pkg::result_t result_s2;
	xcr_pkg::result_t result;
	logic [7:0]       retry_limit_q;
	logic [7:0]       attempt_limit_q;
	logic             adv;

	// Move the held item forward when the output register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q   <= xcr_pkg::RETRY_LIMIT_RST;
			attempt_limit_q <= xcr_pkg::ATTEMPT_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				xcr_pkg::REG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata;
				xcr_pkg::REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tdata[1:0];
			rx_byte_s1 <= s_tdata[9:2];
		end
	end

	xcr_engine u_engine (
		.clk                 (clk),
		.arst_n              (arst_n),
		.en                  (adv),
		.command             (command_s1),
		.rx_byte             (rx_byte_s1),
		.retry_limit         (retry_limit_q),
		.start_attempt_limit (attempt_limit_q),
		.result              (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = xcr_pkg::MDATA_W'(result_s2);

endmodule
